>>> sv/qbdi_pkg.sv
// Shared types and constants for the QRS band-pass, slope and integrator block.
// Used by the controller, the datapath, the top level and the checker.
package qbdi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LPSUM_W  = 40;
  localparam int Q8_W     = 32;
  localparam int HPSUM_W  = 40;
  localparam int WSUM_W   = 24;
  localparam int PROD_W   = 57;
  localparam int DIFF_W   = 58;
  localparam int STEP_W   = 5;

  localparam int DEF_LP_HALF   = 9;
  localparam int DEF_LP_LEN    = 18;
  localparam int DEF_HP_HALF   = 23;
  localparam int DEF_HP_LEN    = 46;
  localparam int DEF_SLOPE_LEN = 4;
  localparam int DEF_WIN_LEN   = 30;

  localparam logic [GAIN_W-1:0] RST_LP_GAIN  = 16'd809;
  localparam logic [GAIN_W-1:0] RST_HP_GAIN  = 16'd1456;
  localparam logic [GAIN_W-1:0] RST_WIN_CEIL = 16'd65535;

  localparam logic [1:0] REG_LP_GAIN  = 2'd0;
  localparam logic [1:0] REG_HP_GAIN  = 2'd1;
  localparam logic [1:0] REG_WIN_CEIL = 2'd2;

  // Sequencer steps, shared by controller and datapath.
  localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [STEP_W-1:0] ST_RD1   = 5'd1;
  localparam logic [STEP_W-1:0] ST_RD2   = 5'd2;
  localparam logic [STEP_W-1:0] ST_LP    = 5'd3;
  localparam logic [STEP_W-1:0] ST_M1    = 5'd4;
  localparam logic [STEP_W-1:0] ST_M2    = 5'd5;
  localparam logic [STEP_W-1:0] ST_HP    = 5'd6;
  localparam logic [STEP_W-1:0] ST_M3    = 5'd7;
  localparam logic [STEP_W-1:0] ST_M4    = 5'd8;
  localparam logic [STEP_W-1:0] ST_D     = 5'd9;
  localparam logic [STEP_W-1:0] ST_FILT  = 5'd10;
  localparam logic [STEP_W-1:0] ST_SLOPE = 5'd11;
  localparam logic [STEP_W-1:0] ST_WIN   = 5'd12;
  localparam logic [STEP_W-1:0] ST_DV1   = 5'd13;
  localparam logic [STEP_W-1:0] ST_DV2   = 5'd14;
  localparam logic [STEP_W-1:0] ST_DV3   = 5'd15;
  localparam logic [STEP_W-1:0] ST_OUT   = 5'd16;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              accept;
    logic              load_out;
  } qbdi_cmd_t;

endpackage

>>> sv/qbdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module qbdi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/qbdi_ctrl.sv
// Sequencer for the filter chain: walks one sample through the datapath steps.
// Depends on qbdi_pkg.
module qbdi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output qbdi_pkg::qbdi_cmd_t cmd
);
  import qbdi_pkg::*;

  logic [STEP_W-1:0] state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept, load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign load     = (state_r == ST_OUT) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RD1;
      end
      ST_OUT: begin
        if (load) state_nxt = ST_IDLE;
      end
      ST_RD1, ST_RD2, ST_LP, ST_M1, ST_M2, ST_HP, ST_M3, ST_M4, ST_D,
      ST_FILT, ST_SLOPE, ST_WIN, ST_DV1, ST_DV2, ST_DV3: begin
        state_nxt = state_r + 5'd1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign cmd.step     = state_r;
  assign cmd.accept   = accept;
  assign cmd.load_out = load;

endmodule

>>> sv/qbdi_datapath.sv
// Datapath of the filter chain: history RAMs, sums, shared multiplier, divider.
// Depends on qbdi_pkg and qbdi_ram.
module qbdi_datapath #(
  parameter int LP_HALF   = qbdi_pkg::DEF_LP_HALF,
  parameter int LP_LEN    = qbdi_pkg::DEF_LP_LEN,
  parameter int HP_HALF   = qbdi_pkg::DEF_HP_HALF,
  parameter int HP_LEN    = qbdi_pkg::DEF_HP_LEN,
  parameter int SLOPE_LEN = qbdi_pkg::DEF_SLOPE_LEN,
  parameter int WIN_LEN   = qbdi_pkg::DEF_WIN_LEN
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qbdi_pkg::qbdi_cmd_t                 cmd,
  input  logic signed [qbdi_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [qbdi_pkg::GAIN_W-1:0]         lp_gain,
  input  logic [qbdi_pkg::GAIN_W-1:0]         hp_gain,
  input  logic [qbdi_pkg::GAIN_W-1:0]         win_ceil,
  output logic signed [qbdi_pkg::SAMPLE_W-1:0] out_filtered,
  output logic [qbdi_pkg::SAMPLE_W-1:0]       out_slope,
  output logic [qbdi_pkg::SAMPLE_W-1:0]       out_integrated
);
  import qbdi_pkg::*;

  localparam int LP_AW  = (LP_LEN > 1) ? $clog2(LP_LEN) : 1;
  localparam int HP_AW  = (HP_LEN > 1) ? $clog2(HP_LEN) : 1;
  localparam int SL_AW  = (SLOPE_LEN > 1) ? $clog2(SLOPE_LEN) : 1;
  localparam int WIN_AW = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int LP_H   = LP_HALF % LP_LEN;
  localparam int HP_H   = HP_HALF % HP_LEN;
  // Reciprocal for the window average; the estimate is low by at most one.
  localparam logic [31:0] WIN_RECIP = 32'(64'hFFFF_FFFF / 64'(WIN_LEN));
  localparam logic [WSUM_W-1:0] WIN_DIV = WSUM_W'(WIN_LEN);

  logic [STEP_W-1:0] step;
  assign step = cmd.step;

  // Indexes and valid bits.
  logic [LP_AW-1:0]  lp_idx_r, lp_half;
  logic [HP_AW-1:0]  hp_idx_r, hp_half;
  logic [SL_AW-1:0]  sl_idx_r;
  logic [WIN_AW-1:0] win_idx_r;
  logic [LP_LEN-1:0]    lp_vld_r;
  logic [HP_LEN-1:0]    hp_vld_r;
  logic [SLOPE_LEN-1:0] sl_vld_r;
  logic [WIN_LEN-1:0]   win_vld_r;
  logic rv_lp_r, rv_hp_r, rv_sl_r, rv_win_r;

  // RAM ports.
  logic [LP_AW-1:0]  lp_raddr;
  logic [HP_AW-1:0]  hp_raddr;
  logic [SAMPLE_W-1:0] lp_rdata, sl_rdata, win_rdata;
  logic [Q8_W-1:0]     hp_rdata;
  logic lp_we, hp_we, sl_we, win_we;
  logic [Q8_W-1:0] q8;

  // Working registers.
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [LPSUM_W-1:0]  lp_p1_r, lp_p2_r, acc_r, y0_r;
  logic signed [HPSUM_W-1:0]  hsum_r;
  logic signed [Q8_W-1:0]     hh_r, hpp_r;
  logic signed [SAMPLE_W-1:0] sd_r, filt_r;
  logic [SAMPLE_W-1:0]        wd_r, slope_r, avg_r;
  logic [LPSUM_W-1:0]         lo_r;
  logic signed [32:0]         hi_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [DIFF_W-1:0]   d_r;
  logic [WSUM_W-1:0]          wsum_r, est_r, ew_r;

  always_comb begin
    if (lp_idx_r >= LP_AW'(LP_H)) lp_half = lp_idx_r - LP_AW'(LP_H);
    else lp_half = lp_idx_r + LP_AW'(LP_LEN - LP_H);
    if (hp_idx_r >= HP_AW'(HP_H)) hp_half = hp_idx_r - HP_AW'(HP_H);
    else hp_half = hp_idx_r + HP_AW'(HP_LEN - HP_H);
  end

  assign lp_raddr = (step == ST_RD1) ? lp_half : lp_idx_r;
  assign hp_raddr = (step == ST_RD1) ? hp_half : hp_idx_r;
  assign lp_we  = (step == ST_LP);
  assign hp_we  = (step == ST_HP);
  assign sl_we  = (step == ST_SLOPE);
  assign win_we = (step == ST_WIN);

  qbdi_ram #(.WIDTH(SAMPLE_W), .DEPTH(LP_LEN)) u_lp_ram (
    .clk(clk), .we(lp_we), .waddr(lp_idx_r), .wdata(x_r),
    .raddr(lp_raddr), .rdata(lp_rdata));
  qbdi_ram #(.WIDTH(Q8_W), .DEPTH(HP_LEN)) u_hp_ram (
    .clk(clk), .we(hp_we), .waddr(hp_idx_r), .wdata(q8),
    .raddr(hp_raddr), .rdata(hp_rdata));
  qbdi_ram #(.WIDTH(SAMPLE_W), .DEPTH(SLOPE_LEN)) u_sl_ram (
    .clk(clk), .we(sl_we), .waddr(sl_idx_r), .wdata(filt_r),
    .raddr(sl_idx_r), .rdata(sl_rdata));
  qbdi_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN_LEN)) u_win_ram (
    .clk(clk), .we(win_we), .waddr(win_idx_r), .wdata(slope_r),
    .raddr(win_idx_r), .rdata(win_rdata));

  // Entries never written since reset read as zero.
  logic signed [SAMPLE_W-1:0] lp_rd;
  logic signed [Q8_W-1:0]     hp_rd;
  assign lp_rd = rv_lp_r ? lp_rdata : '0;
  assign hp_rd = rv_hp_r ? hp_rdata : '0;

  // Shared multiplier: 40-bit operand split into a low 24-bit and high 16-bit part.
  logic signed [LPSUM_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_g;
  assign mul_a = (step == ST_M1) ? y0_r : hsum_r;
  assign mul_g = (step == ST_M1) ? lp_gain : hp_gain;

  logic signed [PROD_W-1:0] prod_sum, q8_full;
  assign prod_sum = ({{(PROD_W-33){hi_r[32]}}, hi_r} <<< 24)
                    + $signed({17'd0, lo_r});
  assign q8_full  = prod_r >>> 8;

  always_comb begin
    if (q8_full > $signed(PROD_W'(64'sh7FFF_FFFF))) q8 = 32'h7FFF_FFFF;
    else if (q8_full < -$signed(PROD_W'(64'sh8000_0000))) q8 = 32'h8000_0000;
    else q8 = q8_full[Q8_W-1:0];
  end

  // Truncation toward zero of the Q24 difference, then 16-bit saturation.
  logic signed [DIFF_W-1:0] d_bias;
  logic signed [DIFF_W-25:0] f_full;
  assign d_bias = d_r[DIFF_W-1] ? d_r + DIFF_W'(24'hFF_FFFF) : d_r;
  assign f_full = d_bias[DIFF_W-1:24];

  logic signed [SAMPLE_W:0] sdiff, sabs;
  assign sdiff = {filt_r[SAMPLE_W-1], filt_r} - {sd_r[SAMPLE_W-1], sd_r};
  assign sabs  = sdiff[SAMPLE_W] ? -sdiff : sdiff;

  logic [55:0] est_full;
  logic [WSUM_W+8:0] ew_full;
  logic [WSUM_W-1:0] rem, qv;
  assign est_full = wsum_r * WIN_RECIP;
  assign ew_full  = est_r * 9'(WIN_LEN);
  assign rem      = wsum_r - ew_r;
  assign qv       = (rem >= WIN_DIV) ? est_r + 24'd1 : est_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_idx_r  <= '0;
      hp_idx_r  <= '0;
      sl_idx_r  <= '0;
      win_idx_r <= '0;
      lp_vld_r  <= '0;
      hp_vld_r  <= '0;
      sl_vld_r  <= '0;
      win_vld_r <= '0;
      lp_p1_r   <= '0;
      lp_p2_r   <= '0;
      hsum_r    <= '0;
      wsum_r    <= '0;
    end else begin
      case (step)
        ST_LP: begin
          lp_p2_r <= lp_p1_r;
          lp_p1_r <= acc_r + LPSUM_W'(lp_rd);
          lp_vld_r[lp_idx_r] <= 1'b1;
          lp_idx_r <= (lp_idx_r == LP_AW'(LP_LEN - 1)) ? '0 : lp_idx_r + 1'b1;
        end
        ST_HP: begin
          hsum_r <= hsum_r + HPSUM_W'($signed(q8)) - HPSUM_W'(hpp_r);
          hp_vld_r[hp_idx_r] <= 1'b1;
          hp_idx_r <= (hp_idx_r == HP_AW'(HP_LEN - 1)) ? '0 : hp_idx_r + 1'b1;
        end
        ST_SLOPE: begin
          sl_vld_r[sl_idx_r] <= 1'b1;
          sl_idx_r <= (sl_idx_r == SL_AW'(SLOPE_LEN - 1)) ? '0 : sl_idx_r + 1'b1;
        end
        ST_WIN: begin
          wsum_r <= wsum_r + WSUM_W'(slope_r) - WSUM_W'(wd_r);
          win_vld_r[win_idx_r] <= 1'b1;
          win_idx_r <= (win_idx_r == WIN_AW'(WIN_LEN - 1)) ? '0 : win_idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) x_r <= in_sample;
    case (step)
      ST_RD1: begin
        rv_lp_r  <= lp_vld_r[lp_half];
        rv_hp_r  <= hp_vld_r[hp_half];
        rv_sl_r  <= sl_vld_r[sl_idx_r];
        rv_win_r <= win_vld_r[win_idx_r];
      end
      ST_RD2: begin
        acc_r <= (lp_p1_r <<< 1) - lp_p2_r + LPSUM_W'(x_r)
                 - (LPSUM_W'(lp_rd) <<< 1);
        hh_r <= hp_rd;
        sd_r <= rv_sl_r ? sl_rdata : '0;
        wd_r <= rv_win_r ? win_rdata : '0;
        rv_lp_r <= lp_vld_r[lp_idx_r];
        rv_hp_r <= hp_vld_r[hp_idx_r];
      end
      ST_LP: begin
        y0_r  <= acc_r + LPSUM_W'(lp_rd);
        hpp_r <= hp_rd;
      end
      ST_M1, ST_M3: begin
        lo_r <= mul_a[23:0] * mul_g;
        hi_r <= $signed(mul_a[39:24]) * $signed({1'b0, mul_g});
      end
      ST_M2, ST_M4: prod_r <= prod_sum;
      ST_D: d_r <= (DIFF_W'(hh_r) <<< 16) - DIFF_W'(prod_r);
      ST_FILT: begin
        if (f_full > 34'sd32767) filt_r <= 16'sh7FFF;
        else if (f_full < -34'sd32768) filt_r <= 16'sh8000;
        else filt_r <= f_full[SAMPLE_W-1:0];
      end
      ST_SLOPE: slope_r <= sabs[SAMPLE_W-1:0];
      ST_DV1: est_r <= est_full[55:32];
      ST_DV2: ew_r <= ew_full[WSUM_W-1:0];
      ST_DV3: avg_r <= (qv > {8'd0, win_ceil}) ? win_ceil : qv[SAMPLE_W-1:0];
      default: ;
    endcase
    if (cmd.load_out) begin
      out_filtered   <= filt_r;
      out_slope      <= slope_r;
      out_integrated <= avg_r;
    end
  end

endmodule

>>> sv/qrs_bandpass_deriv_integrator.sv
// QRS filter chain top level: configuration registers, controller and datapath.
// Depends on qbdi_pkg, qbdi_ctrl and qbdi_datapath.
//
// Usage: one signed 16-bit ECG sample enters per input beat (in_valid high and
// in_stall low at a clock edge). Each sample yields exactly one result beat
// carrying filtered, slope and integrated values.
// The block works on one sample at a time: a new sample is taken only after
// the result of the previous one is loaded into the output register. The
// sequencer walks each sample through history RAM reads, two passes of the
// shared split multiplier and a reciprocal-multiply divide for the window average.
// A finished result waits in the output register while the receiver holds
// out_stall; a next sample can still be taken, and it holds at its last step,
// with in_stall high, until the output register is free again.
// Reset (synchronous, rst_n low) clears all sums, indexes and history valid
// bits, so histories read as zero, and loads the register defaults.
// Registers over APB: 0 lowpass_gain, 4 highpass_gain, 8 window_ceiling;
// write only while no sample is in flight.
module qrs_bandpass_deriv_integrator #(
  parameter int LP_HALF   = qbdi_pkg::DEF_LP_HALF,
  parameter int LP_LEN    = qbdi_pkg::DEF_LP_LEN,
  parameter int HP_HALF   = qbdi_pkg::DEF_HP_HALF,
  parameter int HP_LEN    = qbdi_pkg::DEF_HP_LEN,
  parameter int SLOPE_LEN = qbdi_pkg::DEF_SLOPE_LEN,
  parameter int WIN_LEN   = qbdi_pkg::DEF_WIN_LEN
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [qbdi_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qbdi_pkg::SAMPLE_W-1:0] out_filtered,
  output logic [qbdi_pkg::SAMPLE_W-1:0]       out_slope,
  output logic [qbdi_pkg::SAMPLE_W-1:0]       out_integrated,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import qbdi_pkg::*;

  logic [GAIN_W-1:0] lp_gain_r, hp_gain_r, win_ceil_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  qbdi_cmd_t         cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_gain_r  <= RST_LP_GAIN;
      hp_gain_r  <= RST_HP_GAIN;
      win_ceil_r <= RST_WIN_CEIL;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LP_GAIN:  lp_gain_r  <= pwdata[GAIN_W-1:0];
        REG_HP_GAIN:  hp_gain_r  <= pwdata[GAIN_W-1:0];
        REG_WIN_CEIL: win_ceil_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LP_GAIN:  prdata = {16'd0, lp_gain_r};
      REG_HP_GAIN:  prdata = {16'd0, hp_gain_r};
      REG_WIN_CEIL: prdata = {16'd0, win_ceil_r};
      default:      prdata = '0;
    endcase
  end

  qbdi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd));

  qbdi_datapath #(
    .LP_HALF(LP_HALF), .LP_LEN(LP_LEN), .HP_HALF(HP_HALF), .HP_LEN(HP_LEN),
    .SLOPE_LEN(SLOPE_LEN), .WIN_LEN(WIN_LEN)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_sample(in_sample),
    .lp_gain(lp_gain_r), .hp_gain(hp_gain_r), .win_ceil(win_ceil_r),
    .out_filtered(out_filtered), .out_slope(out_slope),
    .out_integrated(out_integrated));

endmodule

>>> sv/qbdi_checker.sv
// Port-level checks for the QRS filter chain, bound to the top level.
// Depends on qbdi_pkg.
module qbdi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [qbdi_pkg::SAMPLE_W-1:0] out_filtered,
  input logic [qbdi_pkg::SAMPLE_W-1:0]       out_slope,
  input logic [qbdi_pkg::SAMPLE_W-1:0]       out_integrated
);

  // After reset no result beat is pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A taken sample keeps the input side busy while it is worked on.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("input taken again too early");

  // A result cannot appear in the cycle right after a sample is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared without processing time");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_filtered)
    && $stable(out_slope) && $stable(out_integrated))
    else $error("stalled result changed");

endmodule

bind qrs_bandpass_deriv_integrator qbdi_checker u_qbdi_checker (.*);

>>> sim/tb.sv
// Self-checking bench for qrs_bandpass_deriv_integrator: random sample streams, random
// handshake stalls and register changes, each result checked against a filter-chain predictor.
// Depends on qbdi_pkg and the RTL of the block.
module tb;
  import qbdi_pkg::*;

  localparam int LP_HALF   = DEF_LP_HALF;
  localparam int LP_LEN    = DEF_LP_LEN;
  localparam int HP_HALF   = DEF_HP_HALF;
  localparam int HP_LEN    = DEF_HP_LEN;
  localparam int SLOPE_LEN = DEF_SLOPE_LEN;
  localparam int WIN_LEN   = DEF_WIN_LEN;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    logic signed [15:0] filtered;
    logic [15:0]        slope;
    logic [15:0]        integrated;
  } chain_result_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] in_sample, out_filtered;
  logic [15:0] out_slope, out_integrated;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  qrs_bandpass_deriv_integrator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_filtered(out_filtered),
    .out_slope(out_slope), .out_integrated(out_integrated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state, a mirror of the block's histories and sums.
  longint lp_y1, lp_y2, hp_sum, win_sum;
  longint raw_hist[LP_LEN];
  longint q8_hist[HP_LEN];
  longint filt_hist[SLOPE_LEN];
  longint slope_hist[WIN_LEN];
  int lp_pos, hp_pos, sl_pos, win_pos;
  longint gain_lp, gain_hp, ceiling;

  chain_result_t expected_q[$];
  logic signed [15:0] sample_q[$];
  int errors, samples_in, results_out, phases_run;
  bit idle_on;
  int send_gap, recv_hold, long_left, hold_req, hold_seen, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_out, what, got, want);
  endtask

  task automatic predict_chain(input logic signed [15:0] x_in);
    longint x, y0, q8, d, filt, slp, avg;
    logic [39:0] wrap;
    int half;
    begin
      x = x_in;
      half = (lp_pos + LP_LEN - (LP_HALF % LP_LEN)) % LP_LEN;
      wrap = 40'(2 * lp_y1 - lp_y2 + x - 2 * raw_hist[half] + raw_hist[lp_pos]);
      y0 = {{24{wrap[39]}}, wrap};
      lp_y2 = lp_y1;
      lp_y1 = y0;
      raw_hist[lp_pos] = x;
      lp_pos = (lp_pos + 1) % LP_LEN;
      // Arithmetic shift gives the floor for negative products too.
      q8 = (y0 * gain_lp) >>> 8;
      if (q8 > 64'sd2147483647) q8 = 64'sd2147483647;
      if (q8 < -64'sd2147483648) q8 = -64'sd2147483648;

      half = (hp_pos + HP_LEN - (HP_HALF % HP_LEN)) % HP_LEN;
      hp_sum = hp_sum + q8 - q8_hist[hp_pos];
      d = q8_hist[half] * 65536 - hp_sum * gain_hp;
      filt = d / 16777216;
      if (filt > 32767) filt = 32767;
      if (filt < -32768) filt = -32768;
      q8_hist[hp_pos] = q8;
      hp_pos = (hp_pos + 1) % HP_LEN;

      slp = filt - filt_hist[sl_pos];
      if (slp < 0) slp = -slp;
      filt_hist[sl_pos] = filt;
      sl_pos = (sl_pos + 1) % SLOPE_LEN;

      win_sum = win_sum + slp - slope_hist[win_pos];
      avg = win_sum / WIN_LEN;
      if (avg > ceiling) avg = ceiling;
      slope_hist[win_pos] = slp;
      win_pos = (win_pos + 1) % WIN_LEN;

      expected_q.push_back('{filtered: filt[15:0], slope: slp[15:0], integrated: avg[15:0]});
    end
  endtask

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  // Sender: one beat per queued sample, with a random gap after each while idle_on is set.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_chain(in_sample);
        samples_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_sample <= sample_q.pop_front();
          send_gap <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each beat and stalls at random, or for a long stretch on request.
  always @(posedge clk) begin
    chain_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_filtered !== want.filtered) report("filtered", out_filtered, want.filtered);
          if (out_slope !== want.slope) report("slope", out_slope, want.slope);
          if (out_integrated !== want.integrated)
            report("integrated", out_integrated, want.integrated);
        end
        recv_hold <= draw_wait();
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        long_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (long_left > 0) begin
        long_left <= long_left - 1;
        out_stall <= 1'b1;
      end else if (recv_hold > 0 && !(out_valid && !out_stall)) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (out_valid && !out_stall) ? 1'b0 : (recv_hold > 0);
      end
    end
  end

  // Watchdog: counts cycles without a beat while work is outstanding.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (expected_q.size() == 0 && sample_q.size() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    begin
      @(posedge clk);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
        REG_LP_GAIN:  gain_lp = value;
        REG_HP_GAIN:  gain_hp = value;
        REG_WIN_CEIL: ceiling = value;
        default: ;
      endcase
    end
  endtask

  task automatic drain();
    begin
      while (sample_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
      repeat (20) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] ecg_like(input int k);
    int r;
    begin
      r = $urandom_range(0, 9);
      if (r < 2) return 16'($urandom);
      if (r == 2) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      if (k % 40 < 3) return 16'($urandom_range(8000, 32767));
      if (k % 40 < 6) return 16'(0 - $urandom_range(2000, 20000));
      return 16'($urandom_range(0, 600) - 300);
    end
  endfunction

  initial begin
    logic [15:0] lp_set[9] = '{16'd809, 16'd65535, 16'd0, 16'd809, 16'd1,
                               16'd65535, 16'd0, 16'd0, 16'd809};
    logic [15:0] hp_set[9] = '{16'd1456, 16'd65535, 16'd0, 16'd1456, 16'd1,
                               16'd0, 16'd0, 16'd0, 16'd1456};
    logic [15:0] cl_set[9] = '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd5,
                               16'd100, 16'd0, 16'd0, 16'd65535};
    rst_n = 1'b0;
    in_valid = 1'b0; in_sample = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; samples_in = 0; results_out = 0; phases_run = 0;
    send_gap = 0; recv_hold = 0; long_left = 0; hold_req = 0; hold_seen = 0;
    idle_cycles = 0; idle_on = 1'b0;
    lp_y1 = 0; lp_y2 = 0; hp_sum = 0; win_sum = 0;
    lp_pos = 0; hp_pos = 0; sl_pos = 0; win_pos = 0;
    foreach (raw_hist[i]) raw_hist[i] = 0;
    foreach (q8_hist[i]) q8_hist[i] = 0;
    foreach (filt_hist[i]) filt_hist[i] = 0;
    foreach (slope_hist[i]) slope_hist[i] = 0;
    gain_lp = RST_LP_GAIN; gain_hp = RST_HP_GAIN; ceiling = RST_WIN_CEIL;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a full-scale step, the negative extreme, zeros and a fast toggle.
    repeat (4) sample_q.push_back(16'sh7fff);
    repeat (4) sample_q.push_back(16'sh8000);
    repeat (3) sample_q.push_back(16'sh0000);
    for (int i = 0; i < 8; i++) sample_q.push_back(i[0] ? 16'sh7fff : 16'sh8000);
    sample_q.push_back(16'sh0001);
    sample_q.push_back(16'shffff);
    drain();

    for (int ph = 1; ph < 9; ph++) begin
      if (ph == 6) begin
        lp_set[ph] = 16'($urandom); hp_set[ph] = 16'($urandom); cl_set[ph] = 16'($urandom);
      end else if (ph == 7) begin
        lp_set[ph] = 16'($urandom_range(0, 4000)); hp_set[ph] = 16'($urandom_range(0, 4000));
        cl_set[ph] = 16'($urandom_range(0, 2000));
      end
      write_reg(REG_LP_GAIN, lp_set[ph]);
      write_reg(REG_HP_GAIN, hp_set[ph]);
      write_reg(REG_WIN_CEIL, cl_set[ph]);
      idle_on = (ph % 3 != 2);
      for (int k = 0; k < 240; k++) sample_q.push_back(ecg_like(k));
      if (ph == 3) begin
        repeat (10) @(posedge clk);
        hold_req <= hold_req + 1;
      end
      drain();
      phases_run++;
    end
    repeat (40) @(posedge clk);

    $display("covered %0d samples and %0d results over %0d register settings", samples_in,
             results_out, phases_run + 1);
    $display("including saturation, zero gains, zero ceiling and a long output hold");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results left over", errors, expected_q.size());
      $display("tb failed");
    end
    $finish;
  end
endmodule
